// File: hdl/itvw_pkg.sv
// ----------------------------------------------------------------------------
// itvw_pkg: shared types and constants for the interpolation weight block
// Field widths of the request and result channels, the request and pair codes and the reset count.
// ----------------------------------------------------------------------------
package itvw_pkg;

    localparam int INDEX_W = 6;
    localparam int POS_W   = 32;
    localparam int COUNT_W = 7;
    localparam int PAIR_W  = 2;

    typedef logic [INDEX_W-1:0]      t_index;
    typedef logic signed [POS_W-1:0] t_position;
    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic [PAIR_W-1:0]       t_pair;
    typedef logic                    t_func;

    localparam t_func  FUNC_LOAD   = 1'b0;
    localparam t_func  FUNC_QUERY  = 1'b1;
    localparam t_count COUNT_RESET = 7'd2;
    localparam t_pair  PAIR_ONE    = 2'd1;
    localparam t_pair  PAIR_TWO    = 2'd2;

endpackage

// File: hdl/itvw_if.sv
// ----------------------------------------------------------------------------
// itvw_if: request and result channels of the interpolation weight block
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface itvw_req_if
    import itvw_pkg::*;
();
    logic      valid;
    logic      ready;
    t_func     func;
    t_index    entry_index;
    t_position position;

    modport source (output valid, func, entry_index, position, input ready);
    modport sink   (input valid, func, entry_index, position, output ready);
endinterface

interface itvw_res_if
    import itvw_pkg::*;
#(
    parameter int WEIGHT_W = 17
) ();
    logic                valid;
    logic                ready;
    t_index              lower_index;
    logic [WEIGHT_W-1:0] lower_weight;
    t_index              upper_index;
    logic [WEIGHT_W-1:0] upper_weight;
    t_pair               pair_count;
    logic                slot_changed;

    modport source (output valid, lower_index, lower_weight, upper_index,
                    upper_weight, pair_count, slot_changed, input ready);
    modport sink   (input valid, lower_index, lower_weight, upper_index,
                    upper_weight, pair_count, slot_changed, output ready);
endinterface

// File: hdl/interp_table_value_weights.sv
// ----------------------------------------------------------------------------
// interp_table_value_weights: piecewise linear interpolation weights
// Table of ascending sample positions, cached interval, binary search and a
// serial restoring divider for the interpolation fraction.
// ----------------------------------------------------------------------------
//
//   channel     direction  transaction contents
//   ----------  ---------  --------------------------------------------------
//   i_req       in         func, entry_index, position (load or query)
//   o_res       out        index/weight pairs, pair_count, slot_changed
//   i_cfg_*     in         sample_count write (write enable + data)
//
// A load produces no result. A kept interior interval runs the table checks
// CHK_A, CHK_B and CHK_C, the DINIT setup, unless it finds a special case
// WEIGHT_FRAC_BITS divide steps, and EMIT, then returns to idle. A new search
// first runs SRCH0, SRCH1 and the binary search states SISSUE, SCMP, SHIGH.
// i_req is ready only when idle; a held result stalls the next one in EMIT.
// Reset (synchronous, active low) sets the count to 2 and the cache to
// "below the table"; table contents are undefined until loaded.
//
module interp_table_value_weights
    import itvw_pkg::*;
#(
    parameter int TABLE_DEPTH      = 64,
    parameter int VALUE_BITS       = 32,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itvw_req_if.sink          i_req,
    itvw_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  t_count            i_cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int WW    = WEIGHT_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(WEIGHT_FRAC_BITS + 1);
    localparam logic [WW-1:0]    W_ONE    = WW'(1) << WEIGHT_FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WEIGHT_FRAC_BITS - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHK_A  = 4'd1;   // issue read of interval start
    localparam logic [3:0] ST_CHK_B  = 4'd2;   // test start, issue read of end
    localparam logic [3:0] ST_CHK_C  = 4'd3;   // test interval end
    localparam logic [3:0] ST_SRCH0  = 4'd4;   // issue read of entry 0
    localparam logic [3:0] ST_SRCH1  = 4'd5;   // test entry 0
    localparam logic [3:0] ST_SISSUE = 4'd6;   // issue midpoint or high read
    localparam logic [3:0] ST_SCMP   = 4'd7;   // narrow [low, high]
    localparam logic [3:0] ST_SHIGH  = 4'd8;   // pick high or low
    localparam logic [3:0] ST_DINIT  = 4'd9;   // fraction special cases
    localparam logic [3:0] ST_DIV    = 4'd10;  // one quotient bit per cycle
    localparam logic [3:0] ST_EMIT   = 4'd11;  // load output register

    // Control state
    logic [3:0]        r_state, n_state;
    logic              r_below, n_below;      // cached slot is "below table"
    logic [AW-1:0]     r_slot, n_slot;
    logic              r_changed, n_changed;
    logic [AW-1:0]     r_low, n_low;
    logic [AW-1:0]     r_high, n_high;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_count            r_count;
    logic              r_out_valid;

    // Datapath
    logic signed [VALUE_BITS-1:0] r_t, n_t;
    logic signed [VALUE_BITS-1:0] r_lo, n_lo;
    logic signed [VALUE_BITS-1:0] r_hi, n_hi;
    logic [VALUE_BITS-1:0]        r_rem, n_rem;
    logic [VALUE_BITS-1:0]        r_den, n_den;
    logic [WW-1:0]                r_q, n_q;
    logic signed [VALUE_BITS-1:0] r_table [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] r_rd_data;

    // Output register
    t_index        r_lower_index, r_upper_index;
    logic [WW-1:0] r_lower_weight, r_upper_weight;
    t_pair         r_pair_count;
    logic          r_slot_changed;

    logic signed [VALUE_BITS-1:0] w_key;
    logic [AW-1:0]                w_last;
    logic [AW-1:0]                w_rd_addr;
    logic [AW:0]                  w_sum;
    logic [AW-1:0]                w_mid;
    logic                         w_narrow;
    logic [VALUE_BITS:0]          w_two_rem;
    logic                         w_ge;
    logic                         w_req_fire;
    logic                         w_load_we;
    logic                         w_emit;

    assign w_key      = VALUE_BITS'(i_req.position);
    assign w_req_fire = i_req.valid && i_req.ready;
    assign w_load_we  = w_req_fire && (i_req.func == FUNC_LOAD)
                        && (32'(i_req.entry_index) < 32'(TABLE_DEPTH));
    assign w_emit     = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);

    assign i_req.ready = (r_state == ST_IDLE);

    // Clamp the entry count to 1..TABLE_DEPTH and take the last index
    always_comb begin
        if (r_count == '0) begin
            w_last = '0;
        end else if (32'(r_count) > 32'(TABLE_DEPTH)) begin
            w_last = AW'(TABLE_DEPTH - 1);
        end else begin
            w_last = AW'(32'(r_count) - 32'd1);
        end
    end

    // Binary search midpoint; keep narrowing while high - low > 1
    assign w_sum    = {1'b0, r_low} + {1'b0, r_high};
    assign w_mid    = w_sum[AW:1];
    assign w_narrow = {1'b0, r_high} > ({1'b0, r_low} + (AW+1)'(1));

    // Restoring division step: remainder stays below the divisor
    assign w_two_rem = {r_rem, 1'b0};
    assign w_ge      = w_two_rem >= {1'b0, r_den};

    // Table read address by state
    always_comb begin
        case (r_state)
            ST_CHK_A:  w_rd_addr = r_below ? '0 : r_slot;
            ST_CHK_B:  w_rd_addr = (r_slot < w_last) ? r_slot + AW'(1) : r_slot;
            ST_SRCH0:  w_rd_addr = '0;
            ST_SISSUE: w_rd_addr = w_narrow ? w_mid : r_high;
            default:   w_rd_addr = r_slot;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_below   = r_below;
        n_slot    = r_slot;
        n_changed = r_changed;
        n_low     = r_low;
        n_high    = r_high;
        n_cnt     = r_cnt;
        n_t       = r_t;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_rem     = r_rem;
        n_den     = r_den;
        n_q       = r_q;
        case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    if (i_req.func == FUNC_LOAD) begin
                        n_below = 1'b1;
                    end else begin
                        n_t       = w_key;
                        n_changed = 1'b0;
                        n_state   = ST_CHK_A;
                    end
                end
            end
            ST_CHK_A: begin
                if (!r_below && (r_slot > w_last)) begin
                    n_state = ST_SRCH0;
                end else begin
                    n_state = ST_CHK_B;
                end
            end
            ST_CHK_B: begin
                n_lo = r_rd_data;
                if (r_below) begin
                    n_state = (r_t <= r_rd_data) ? ST_EMIT : ST_SRCH0;
                end else if (r_slot == w_last) begin
                    n_state = (r_t >= r_rd_data) ? ST_EMIT : ST_SRCH0;
                end else begin
                    n_state = (r_t >= r_rd_data) ? ST_CHK_C : ST_SRCH0;
                end
            end
            ST_CHK_C: begin
                n_hi    = r_rd_data;
                n_state = (r_t <= r_rd_data) ? ST_DINIT : ST_SRCH0;
            end
            ST_SRCH0: begin
                n_changed = 1'b1;
                n_low     = '0;
                n_high    = w_last;
                n_state   = ST_SRCH1;
            end
            ST_SRCH1: begin
                if (r_rd_data >= r_t) begin
                    n_below = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SISSUE;
                end
            end
            ST_SISSUE: begin
                n_state = w_narrow ? ST_SCMP : ST_SHIGH;
            end
            ST_SCMP: begin
                // The midpoint is unchanged since the read was issued
                if (r_rd_data < r_t) begin
                    n_low = w_mid;
                end else begin
                    n_high = w_mid;
                end
                n_state = ST_SISSUE;
            end
            ST_SHIGH: begin
                // Entry low is always below t here, so -1 cannot come out
                n_below = 1'b0;
                n_slot  = (r_rd_data < r_t) ? r_high : r_low;
                // Above the table needs no fraction; otherwise re-read the pair
                if ((r_rd_data < r_t) && (r_high == w_last)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_CHK_A;
                end
            end
            ST_DINIT: begin
                n_q   = '0;
                n_cnt = '0;
                n_rem = VALUE_BITS'(r_t - r_lo);
                n_den = VALUE_BITS'(r_hi - r_lo);
                if ((r_hi <= r_lo) || (r_t <= r_lo)) begin
                    n_state = ST_EMIT;
                end else if (r_t >= r_hi) begin
                    n_q     = W_ONE;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_q   = {r_q[WW-2:0], w_ge};
                n_rem = w_ge ? VALUE_BITS'(w_two_rem - {1'b0, r_den})
                             : VALUE_BITS'(w_two_rem);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_below     <= 1'b1;
            r_slot      <= '0;
            r_changed   <= 1'b0;
            r_low       <= '0;
            r_high      <= '0;
            r_cnt       <= '0;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_below   <= n_below;
            r_slot    <= n_slot;
            r_changed <= n_changed;
            r_low     <= n_low;
            r_high    <= n_high;
            r_cnt     <= n_cnt;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    // Sample table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_table[AW'(i_req.entry_index)] <= w_key;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    // Output register: below, above or an interior pair
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_slot_changed <= r_changed;
            if (r_below || (r_slot == w_last)) begin
                r_lower_index  <= r_below ? '0 : INDEX_W'(w_last);
                r_lower_weight <= W_ONE;
                r_upper_index  <= '0;
                r_upper_weight <= '0;
                r_pair_count   <= PAIR_ONE;
            end else begin
                r_lower_index  <= INDEX_W'(r_slot);
                r_lower_weight <= W_ONE - r_q;
                r_upper_index  <= INDEX_W'(r_slot + AW'(1));
                r_upper_weight <= r_q;
                r_pair_count   <= PAIR_TWO;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.lower_index  = r_lower_index;
    assign o_res.lower_weight = r_lower_weight;
    assign o_res.upper_index  = r_upper_index;
    assign o_res.upper_weight = r_upper_weight;
    assign o_res.pair_count   = r_pair_count;
    assign o_res.slot_changed = r_slot_changed;

endmodule

// File: verif/interp_table_value_weights_test.sv
// ----------------------------------------------------------------------------
// interp_table_value_weights_test: self-checking bench for the weight block
// Drives load and query transactions with random gaps, mirrors the table, the
// cached interval and the count in a local predictor, and compares each
// result transaction field by field with the oldest expected weights.
// ----------------------------------------------------------------------------
module interp_table_value_weights_test;
    import itvw_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          FRAC_BITS    = 16;
    localparam int          WEIGHT_W     = FRAC_BITS + 1;
    localparam int          SETTLE       = 48;    // longest query latency, rounded up
    localparam int          STALL_LIMIT  = 2000;  // cycles without any transaction
    localparam int          PHASE_ITEMS  = 200;
    localparam int          IDLE_PCT     = 13;
    localparam int          REPORT_MAX   = 10;
    localparam t_position   POS_MIN      = 32'sh8000_0000;
    localparam t_position   POS_MAX      = 32'sh7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;

    // One result transaction as the block presents it.
    typedef struct packed {
        t_index              lower_index;
        logic [WEIGHT_W-1:0] lower_weight;
        t_index              upper_index;
        logic [WEIGHT_W-1:0] upper_weight;
        t_pair               pair_count;
        logic                slot_changed;
    } weights_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_count i_cfg_data;

    itvw_req_if                       req_if ();
    itvw_res_if #(.WEIGHT_W(WEIGHT_W)) res_if ();

    interp_table_value_weights #(
        .TABLE_DEPTH      (DEPTH),
        .VALUE_BITS       (32),
        .WEIGHT_FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: mirror of the sample table, the cached interval
    // (-1 below the table, last entry in use means above) and the count.
    t_position pos_table [DEPTH];
    int        cached_interval;
    t_count    count_reg;
    t_position recent_query;

    weights_t  pending_weights [$];
    int        mismatches;
    int        idle_cycles;
    bit        steady;          // set for a stretch with no idling on either side

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Entries in use: a count of zero acts as one, anything past the table
    // depth acts as the depth.
    function automatic int active_entries();
        if (count_reg < 1)
            return 1;
        if (count_reg > DEPTH)
            return DEPTH;
        return int'(count_reg);
    endfunction

    // Binary search for the last entry strictly below t, -1 if none. Runs as
    // is on an unsorted table.
    function automatic int find_interval(int n, t_position t);
        int low;
        int high;
        int mid;
        low  = 0;
        high = n - 1;
        if (pos_table[0] >= t)
            return -1;
        while (high - low > 1) begin
            mid = (low + high) / 2;
            if (pos_table[mid] < t)
                low = mid;
            else
                high = mid;
        end
        if (pos_table[high] < t)
            return high;
        if (pos_table[low] < t)
            return low;
        return -1;
    endfunction

    // Truncated fraction of t across [lo, hi]. A zero or negative width and
    // a position at or before the start give zero; at or past the end, one.
    function automatic logic [WEIGHT_W-1:0] interval_fraction(t_position lo, t_position hi,
                                                              t_position t);
        longint num;
        longint den;
        if (hi <= lo || t <= lo)
            return '0;
        if (t >= hi)
            return WEIGHT_ONE;
        num = longint'(t) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        return WEIGHT_W'((num << FRAC_BITS) / den);
    endfunction

    // Expected weights of one query; updates the cached interval.
    function automatic weights_t compute_weights(t_position t);
        weights_t            w;
        int                  n;
        int                  last;
        int                  s;
        bit                  keep;
        logic [WEIGHT_W-1:0] f;
        n    = active_entries();
        last = n - 1;
        s    = cached_interval;
        keep = (s == -1 && t <= pos_table[0])
            || (s >= 0 && s < last && t >= pos_table[s] && t <= pos_table[s + 1])
            || (s == last && t >= pos_table[last]);
        w = '0;
        if (!keep) begin
            s               = find_interval(n, t);
            cached_interval = s;
            w.slot_changed  = 1'b1;
        end
        if (s < 0 || s >= last) begin
            w.lower_index  = (s < 0) ? t_index'(0) : t_index'(last);
            w.lower_weight = WEIGHT_ONE;
            w.pair_count   = PAIR_ONE;
        end else begin
            f              = interval_fraction(pos_table[s], pos_table[s + 1], t);
            w.lower_index  = t_index'(s);
            w.lower_weight = WEIGHT_ONE - f;
            w.upper_index  = t_index'(s + 1);
            w.upper_weight = f;
            w.pair_count   = PAIR_TWO;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Send one request transaction. Inputs change at the falling edge, the
    // handshake is sampled at the rising edge. On acceptance, fold the
    // request into the predictor before anything else can happen.
    task automatic send_transaction(t_func func, t_index idx, t_position pos);
        if (!steady) begin
            while ($urandom_range(99, 0) < IDLE_PCT) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid       = 1'b1;
        req_if.func        = func;
        req_if.entry_index = idx;
        req_if.position    = pos;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        if (func == FUNC_LOAD) begin
            pos_table[idx]  = pos;
            cached_interval = -1;
        end else begin
            pending_weights.push_back(compute_weights(pos));
            recent_query = pos;
        end
        @(negedge i_clk);
        // Drop valid; a following call raises it again in the same step.
        req_if.valid = 1'b0;
    endtask

    task automatic load_entry(int idx, t_position pos);
        send_transaction(FUNC_LOAD, t_index'(idx), pos);
    endtask

    task automatic query_at(t_position pos);
        send_transaction(FUNC_QUERY, t_index'($urandom), pos);
    endtask

    // Change the count only with the block idle: drain every expected result,
    // then hold off for a full query latency before the write.
    task automatic write_sample_count(t_count value);
        while (pending_weights.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        count_reg  = value;
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------

    // Stall the result channel at random except during a steady stretch.
    always @(negedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        weights_t got;
        weights_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.lower_index  = res_if.lower_index;
            got.lower_weight = res_if.lower_weight;
            got.upper_index  = res_if.upper_index;
            got.upper_weight = res_if.upper_weight;
            got.pair_count   = res_if.pair_count;
            got.slot_changed = res_if.slot_changed;
            if (pending_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result with nothing expected: lo %0d/%0d up %0d/%0d pairs %0d chg %0d",
                             got.lower_index, got.lower_weight, got.upper_index,
                             got.upper_weight, got.pair_count, got.slot_changed);
            end else begin
                want = pending_weights.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("ERROR: weights mismatch");
                        $display("  expected lo %0d/%0d up %0d/%0d pairs %0d chg %0d",
                                 want.lower_index, want.lower_weight, want.upper_index,
                                 want.upper_weight, want.pair_count, want.slot_changed);
                        $display("  actual   lo %0d/%0d up %0d/%0d pairs %0d chg %0d",
                                 got.lower_index, got.lower_weight, got.upper_index,
                                 got.upper_weight, got.pair_count, got.slot_changed);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on any port for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_position clamp_position(longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return t_position'(v);
    endfunction

    // Uniform pick in [lo, hi], hi >= lo, over the full 32-bit span.
    function automatic t_position pick_between(longint lo, longint hi);
        longint unsigned raw;
        raw = {$urandom, $urandom};
        return t_position'(lo + longint'(raw % unsigned'(hi - lo + 1)));
    endfunction

    // Query position: mostly inside or on the edges of intervals in use,
    // a good share close to the last query so the cached interval is hit,
    // plus positions below, above and anywhere.
    function automatic t_position pick_query_position(int n);
        int     j;
        int     sel;
        longint lo;
        longint hi;
        j   = $urandom_range(n - 1, 0);
        sel = $urandom_range(99, 0);
        lo  = pos_table[j];
        if (sel < 8)
            return t_position'($urandom);
        if (sel < 16)
            return clamp_position(longint'(pos_table[0]) - int'($urandom_range(4096, 0)));
        if (sel < 24)
            return clamp_position(longint'(pos_table[n - 1]) + int'($urandom_range(4096, 0)));
        if (sel < 44)
            return clamp_position(lo + int'($urandom_range(2, 0)) - 1);
        if (sel < 70)
            return clamp_position(longint'(recent_query) + int'($urandom_range(8192, 0)) - 4096);
        if (j == n - 1)
            return pos_table[j];
        hi = pos_table[j + 1];
        if (hi <= lo)
            return pos_table[j];
        return pick_between(lo, hi);
    endfunction

    // Load all entries with a strictly ascending set; spacing mixes tiny,
    // Q16.16-unit and very wide steps.
    task automatic fill_sorted_table();
        longint pos;
        int     j;
        pos = longint'(POS_MIN) + int'($urandom_range(1 << 20, 0));
        for (j = 0; j < DEPTH; j++) begin
            load_entry(j, t_position'(pos));
            case ($urandom_range(2, 0))
                0:       pos += $urandom_range(4, 1);
                1:       pos += $urandom_range(1 << 16, 1);
                default: pos += $urandom_range(1 << 25, 1);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset count of two, entries at the extremes of the position range.
    task automatic test_full_span();
        load_entry(0, POS_MIN);
        load_entry(1, POS_MAX);
        query_at(POS_MIN);      // below the table, interval kept
        query_at(32'sd0);       // search, inside
        query_at(POS_MAX);      // kept, at the end of the interval
        query_at(-32'sd1);
    endtask

    // Repeated entry, kept intervals hit at both ends, above and below.
    task automatic test_shared_entries();
        write_sample_count(7'd4);
        load_entry(0, -32'sh0003_0000);
        load_entry(1, 32'sh0001_0000);
        load_entry(2, 32'sh0001_0000);
        load_entry(3, POS_MAX);
        query_at(-32'sh0004_0000);  // below
        query_at(32'sh0001_0000);   // search, lands at the interval end
        query_at(32'sh0001_0000);   // same position, interval kept
        query_at(32'sh0001_8000);   // search past the repeated entry
        query_at(POS_MAX);          // kept interval reaches the top entry
        query_at(32'sh0001_0000);   // kept, position at the interval start
    endtask

    // Shrink the count under a cached interval, then the zero count.
    task automatic test_count_limits();
        write_sample_count(7'd1);
        query_at(32'sh0001_0000);   // stale interval forces a search
        query_at(-32'sh0003_0000);  // single entry, kept above
        write_sample_count(7'd0);
        query_at(-32'sh0004_0000);  // zero acts as one entry
    endtask

    // Descending neighbours: the search still runs by midpoints.
    task automatic test_unsorted();
        write_sample_count(7'd4);
        load_entry(0, 32'sh0001_0000);
        load_entry(1, 32'sh0004_0000);
        load_entry(2, 32'sh0000_8000);
        load_entry(3, 32'sh0003_0000);
        query_at(32'sh0002_0000);
        query_at(32'sh0003_8000);
        query_at(32'sh0005_0000);
        query_at(32'sh0000_8000);
    endtask

    // One random phase at a given count: mostly queries, a few loads that
    // either keep the order or drop an arbitrary value into the table.
    task automatic run_weight_phase(t_count value, bit refill, bit no_gaps);
        int     k;
        int     j;
        longint lo;
        longint hi;
        write_sample_count(value);
        if (refill)
            fill_sorted_table();
        steady = no_gaps;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99, 0) < 6) begin
                j = $urandom_range(DEPTH - 1, 0);
                if ($urandom_range(4, 0) == 0) begin
                    load_entry(j, t_position'($urandom));
                end else begin
                    lo = (j > 0) ? longint'(pos_table[j - 1]) + 1 : longint'(POS_MIN);
                    hi = (j < DEPTH - 1) ? longint'(pos_table[j + 1]) - 1 : longint'(POS_MAX);
                    if (hi >= lo)
                        load_entry(j, pick_between(lo, hi));
                    else
                        load_entry(j, pos_table[j]);
                end
            end else begin
                query_at(pick_query_position(active_entries()));
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_sweep();
        run_weight_phase(7'd64, 1'b1, 1'b0);
        run_weight_phase(7'd127, 1'b0, 1'b1);   // full stretch with no idling
        run_weight_phase(t_count'($urandom_range(63, 2)), 1'b1, 1'b0);
        run_weight_phase(7'd1, 1'b0, 1'b0);
        run_weight_phase(7'd0, 1'b0, 1'b0);
        run_weight_phase(t_count'($urandom_range(126, 65)), 1'b1, 1'b0);
        run_weight_phase(7'd32, 1'b0, 1'b0);
        run_weight_phase(t_count'($urandom_range(64, 2)), 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_LOAD;
        req_if.entry_index = '0;
        req_if.position    = '0;
        res_if.ready       = 1'b0;
        steady             = 1'b0;
        mismatches         = 0;
        idle_cycles        = 0;
        cached_interval    = -1;
        count_reg          = COUNT_RESET;
        recent_query       = '0;
        foreach (pos_table[j])
            pos_table[j] = '0;

        // Hold reset, then release it at a falling edge.
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_full_span();
        test_shared_entries();
        test_count_limits();
        test_unsorted();
        test_random_sweep();

        // Drain outstanding results, then allow one query latency for
        // anything unexpected to show up.
        while (pending_weights.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: interp_table_value_weights.f
hdl/itvw_pkg.sv
hdl/itvw_if.sv
hdl/interp_table_value_weights.sv
verif/interp_table_value_weights_test.sv
